@@ src/pps_pkg.sv @@
// shared types and constants of the preemptive priority scheduler
`default_nettype none

package pps_pkg;

	// default sizes of the task table and its fields
	localparam int DEF_MAX_TASKS  = 16;
	localparam int DEF_TIME_WIDTH = 16;
	localparam int DEF_PRIO_WIDTH = 8;

	// entries of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	localparam int TASK_COUNT_W = 5;
	localparam logic [TASK_COUNT_W-1:0] TASK_COUNT_RESET = 5'd1;

	typedef logic [1:0]  opcode_t;
	typedef logic [3:0]  task_idx_t;
	typedef logic [15:0] time_field_t;
	typedef logic [7:0]  prio_field_t;
	typedef logic [15:0] wait_ticks_t;
	typedef logic [16:0] turn_ticks_t;
	typedef logic [TASK_COUNT_W-1:0] task_count_t;

	localparam opcode_t OP_LOAD  = 2'd0;
	localparam opcode_t OP_TICK  = 2'd1;
	localparam opcode_t OP_QUERY = 2'd2;

	typedef struct packed {
		opcode_t     opcode;
		task_idx_t   task_index;
		time_field_t arrival_time;
		time_field_t burst_length;
		prio_field_t task_priority;
	} request_t;

	typedef struct packed {
		task_idx_t   running_index;
		logic        running_valid;
		logic        all_finished;
		wait_ticks_t wait_ticks;
		turn_ticks_t turnaround_ticks;
		logic        is_query_reply;
	} result_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_TICK,
		CMD_QUERY
	} cmd_kind_t;

	// a classified request as it travels through the queue
	typedef struct packed {
		cmd_kind_t   kind;
		logic        idx_ok;
		task_idx_t   task_index;
		time_field_t arrival_time;
		time_field_t burst_length;
		prio_field_t task_priority;
	} cmd_t;

endpackage

`default_nettype wire

@@ src/pps_front.sv @@
// request intake: accepts, classifies and stages requests for the queue
`default_nettype none

module pps_front #(
	parameter int MAX_TASKS = pps_pkg::DEF_MAX_TASKS
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  pps_pkg::request_t request,
	output logic             busy,
	output logic             q_push,
	output pps_pkg::cmd_t    q_data,
	input  wire              q_full
);

	logic          vld_s1;
	pps_pkg::cmd_t cmd_s1;
	pps_pkg::cmd_t cmd_d;
	logic          keep;
	logic          accept;

	assign busy   = vld_s1 && q_full;
	assign accept = start && !busy;
	assign q_push = vld_s1 && !q_full;
	assign q_data = cmd_s1;

	always_comb begin
		cmd_d.kind          = pps_pkg::CMD_LOAD;
		cmd_d.idx_ok        = int'(request.task_index) < MAX_TASKS;
		cmd_d.task_index    = request.task_index;
		cmd_d.arrival_time  = request.arrival_time;
		cmd_d.burst_length  = request.burst_length;
		cmd_d.task_priority = request.task_priority;
		keep                = 1'b1;
		case (request.opcode)
			pps_pkg::OP_LOAD: begin
				cmd_d.kind = pps_pkg::CMD_LOAD;
				// a load beyond the table does nothing
				keep       = cmd_d.idx_ok;
			end
			pps_pkg::OP_TICK: begin
				cmd_d.kind = pps_pkg::CMD_TICK;
			end
			pps_pkg::OP_QUERY: begin
				cmd_d.kind = pps_pkg::CMD_QUERY;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= keep;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

`default_nettype wire

@@ src/pps_queue.sv @@
// short request queue between intake and execution
`default_nettype none

module pps_queue (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push,
	input  pps_pkg::cmd_t push_data,
	output logic          full,
	input  wire           pop,
	output logic          valid,
	output pps_pkg::cmd_t head
);

	localparam int QD = pps_pkg::QUEUE_DEPTH;
	localparam int PW = (QD > 1) ? $clog2(QD) : 1;
	localparam int CW = $clog2(QD + 1);

	pps_pkg::cmd_t   mem_q [QD];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = count_q == CW'(QD);
	assign valid   = count_q != '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ src/pps_back.sv @@
// execution of loads, ticks and queries over the task table
`default_nettype none

module pps_back #(
	parameter int MAX_TASKS  = pps_pkg::DEF_MAX_TASKS,
	parameter int TIME_WIDTH = pps_pkg::DEF_TIME_WIDTH,
	parameter int PRIO_WIDTH = pps_pkg::DEF_PRIO_WIDTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  pps_pkg::task_count_t cfg_wdata,
	input  wire                  q_valid,
	input  pps_pkg::cmd_t        q_head,
	output logic                 q_pop,
	output logic                 result_valid,
	output pps_pkg::result_t     result
);

	localparam int TW = TIME_WIDTH;
	localparam int PW = PRIO_WIDTH;
	localparam int SW = TIME_WIDTH + 1;
	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef struct packed {
		logic [TW-1:0] arrival;
		logic [TW-1:0] burst;
		logic [TW-1:0] remaining;
		logic [PW-1:0] prio;
	} ent_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH,
		ST_QREAD,
		ST_QREPLY
	} state_t;

	ent_t                 task_mem [MAX_TASKS];
	logic [TW-1:0]        wait_mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] wait_vld_q;
	logic [MAX_TASKS-1:0] pending_q;

	state_t               state_q;
	pps_pkg::cmd_t        cmd_q;
	pps_pkg::task_count_t task_count_q;
	logic [TW-1:0]        tick_q;
	logic [IW-1:0]        scan_idx_q;
	logic                 eval_vld_s1;
	logic [IW-1:0]        eval_idx_s1;
	ent_t                 rd_ent_s1;
	logic [TW-1:0]        rd_wait_s1;
	logic                 rd_wvld_s1;
	logic                 best_vld_q;
	logic [IW-1:0]        best_idx_q;
	ent_t                 best_ent_q;
	logic                 best_incr_q;
	logic [TW-1:0]        best_wait_q;
	logic                 result_valid_q;
	pps_pkg::result_t     result_q;

	logic [CW-1:0]        n_eff;
	logic [MAX_TASKS-1:0] use_mask;
	logic                 scan_last;
	logic [IW-1:0]        cmd_addr;
	logic [IW-1:0]        rd_addr;
	logic [TW-1:0]        wait_cur;
	logic                 cand_ready;
	logic                 wait_inc;
	logic                 cand_better;
	logic [TW-1:0]        best_rem_dec;
	ent_t                 load_ent;
	logic                 task_we;
	logic [IW-1:0]        task_waddr;
	ent_t                 task_wdata;
	logic                 wait_we;
	logic [IW-1:0]        wait_waddr;
	logic [TW-1:0]        wait_wdata;
	logic [MAX_TASKS-1:0] pend_d;
	logic                 all_fin_d;
	logic [SW-1:0]        q_sum;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// zero tasks acts as one, too many as the full table
	always_comb begin
		if (task_count_q == '0) begin
			n_eff = CW'(1);
		end else if (int'(task_count_q) > MAX_TASKS) begin
			n_eff = CW'(MAX_TASKS);
		end else begin
			n_eff = CW'(task_count_q);
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_TASKS; j++) begin
			use_mask[j] = j < int'(n_eff);
		end
	end

	assign scan_last = (CW'(scan_idx_q) + CW'(1)) == n_eff;
	assign cmd_addr  = IW'(cmd_q.task_index);
	assign rd_addr   = (state_q == ST_SCAN) ? scan_idx_q : cmd_addr;

	// never-written wait entries read as zero
	assign wait_cur    = rd_wvld_s1 ? rd_wait_s1 : '0;
	assign cand_ready  = eval_vld_s1 && (rd_ent_s1.arrival <= tick_q) &&
		pending_q[eval_idx_s1];
	assign wait_inc    = cand_ready && (wait_cur != '1);
	assign cand_better = cand_ready && (!best_vld_q ||
		(rd_ent_s1.prio < best_ent_q.prio) ||
		((rd_ent_s1.prio == best_ent_q.prio) &&
		 (rd_ent_s1.arrival <= best_ent_q.arrival)));
	assign best_rem_dec = best_ent_q.remaining - TW'(1);

	always_comb begin
		load_ent.arrival   = TW'(cmd_q.arrival_time);
		load_ent.burst     = TW'(cmd_q.burst_length);
		load_ent.remaining = TW'(cmd_q.burst_length);
		load_ent.prio      = PW'(cmd_q.task_priority);
	end

	always_comb begin
		task_we    = 1'b0;
		task_waddr = best_idx_q;
		task_wdata = best_ent_q;
		task_wdata.remaining = best_rem_dec;
		if (state_q == ST_LOAD) begin
			task_we    = cmd_q.idx_ok;
			task_waddr = cmd_addr;
			task_wdata = load_ent;
		end else if (state_q == ST_FINISH) begin
			task_we = best_vld_q;
		end
	end

	// every ready task is counted as waiting during the scan, the winner is undone at the end
	always_comb begin
		if (state_q == ST_FINISH) begin
			wait_we    = best_vld_q && best_incr_q;
			wait_waddr = best_idx_q;
			wait_wdata = best_wait_q - TW'(1);
		end else begin
			wait_we    = wait_inc;
			wait_waddr = eval_idx_s1;
			wait_wdata = wait_cur + TW'(1);
		end
	end

	always_comb begin
		pend_d = pending_q;
		if (state_q == ST_LOAD && cmd_q.idx_ok) begin
			pend_d[cmd_addr] = load_ent.burst != '0;
		end else if (state_q == ST_FINISH && best_vld_q) begin
			pend_d[best_idx_q] = best_rem_dec != '0;
		end
	end

	assign all_fin_d = ~|(pend_d & use_mask);
	assign q_sum     = SW'(rd_ent_s1.burst) + SW'(wait_cur);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		if (task_we) begin
			task_mem[task_waddr] <= task_wdata;
		end
		rd_ent_s1 <= task_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wait_we) begin
			wait_mem[wait_waddr] <= wait_wdata;
		end
		rd_wait_s1 <= wait_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_vld_q <= '0;
			rd_wvld_s1 <= 1'b0;
		end else begin
			if (wait_we) begin
				wait_vld_q[wait_waddr] <= 1'b1;
			end
			rd_wvld_s1 <= wait_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cmd_q          <= '0;
			task_count_q   <= pps_pkg::TASK_COUNT_RESET;
			tick_q         <= '0;
			pending_q      <= '0;
			scan_idx_q     <= '0;
			eval_vld_s1    <= 1'b0;
			eval_idx_s1    <= '0;
			best_vld_q     <= 1'b0;
			best_idx_q     <= '0;
			best_ent_q     <= '0;
			best_incr_q    <= 1'b0;
			best_wait_q    <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			pending_q      <= pend_d;
			if (cfg_we) begin
				task_count_q <= cfg_wdata;
			end
			if (cand_better) begin
				best_vld_q  <= 1'b1;
				best_idx_q  <= eval_idx_s1;
				best_ent_q  <= rd_ent_s1;
				best_incr_q <= wait_inc;
				best_wait_q <= wait_inc ? wait_cur + TW'(1) : wait_cur;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q <= q_head;
						case (q_head.kind)
							pps_pkg::CMD_LOAD: begin
								state_q <= ST_LOAD;
							end
							pps_pkg::CMD_TICK: begin
								scan_idx_q  <= '0;
								eval_vld_s1 <= 1'b0;
								best_vld_q  <= 1'b0;
								state_q     <= ST_SCAN;
							end
							pps_pkg::CMD_QUERY: begin
								state_q <= ST_QREAD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_LOAD: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					eval_vld_s1 <= 1'b1;
					eval_idx_s1 <= scan_idx_q;
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					eval_vld_s1 <= 1'b0;
					state_q     <= ST_FINISH;
				end
				ST_FINISH: begin
					if (tick_q != '1) begin
						tick_q <= tick_q + TW'(1);
					end
					result_q                  <= '0;
					result_q.running_index    <= best_vld_q ?
						pps_pkg::task_idx_t'(best_idx_q) : '0;
					result_q.running_valid    <= best_vld_q;
					result_q.all_finished     <= all_fin_d;
					result_valid_q            <= 1'b1;
					state_q                   <= ST_IDLE;
				end
				ST_QREAD: begin
					state_q <= ST_QREPLY;
				end
				ST_QREPLY: begin
					result_q                  <= '0;
					result_q.all_finished     <= all_fin_d;
					result_q.is_query_reply   <= 1'b1;
					if (cmd_q.idx_ok) begin
						result_q.wait_ticks       <= pps_pkg::wait_ticks_t'(wait_cur);
						result_q.turnaround_ticks <= pps_pkg::turn_ticks_t'(q_sum);
					end
					result_valid_q            <= 1'b1;
					state_q                   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_result_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |=> !result_valid_q)
		else $error("result strobe held for more than one cycle");

	a_winner_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && best_vld_q) |-> pending_q[best_idx_q])
		else $error("selected task has no work left");

	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_q != $past(tick_q)) |-> (tick_q == $past(tick_q) + TW'(1)))
		else $error("tick counter moved by other than one");

	a_eval_follows_scan: assert property (@(posedge clk) disable iff (!arst_n)
		eval_vld_s1 |-> ($past(state_q) == ST_SCAN))
		else $error("entry evaluated without a read issued by the scan");

endmodule

`default_nettype wire

@@ src/preemptive_priority_scheduler.sv @@
// top level of the tick-driven preemptive priority scheduler
//
// requests: raise start with request; it is taken at a clock edge where busy
// is low. opcode load writes one task entry, tick runs one time step, query
// reads one task's wait and turnaround. opcode 3 is dropped.
// results: a tick or a query gives one result on result, marked by
// result_valid for exactly one cycle; a load gives none. the receiver cannot
// stall, so results are never held back.
// configuration: cfg_we writes cfg_wdata into the task count; write it only
// while no request is outstanding.
// timing: a request is registered in intake, then waits in a two-entry
// queue while an earlier one executes. a load executes in the load state,
// a query in the read and reply states, a tick in the scan, which reads
// one table entry per cycle through the shared read address of the table
// memories, then in the drain and finish states, where the winner's counts
// are written back. results are registered in the last execution state.
// reset: the tick counter and all wait counts read zero, task count is one,
// the queue is empty; task entries hold nothing until loaded.
`default_nettype none

module preemptive_priority_scheduler #(
	parameter int MAX_TASKS  = pps_pkg::DEF_MAX_TASKS,
	parameter int TIME_WIDTH = pps_pkg::DEF_TIME_WIDTH,
	parameter int PRIO_WIDTH = pps_pkg::DEF_PRIO_WIDTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  pps_pkg::task_count_t cfg_wdata,
	input  wire                  start,
	input  pps_pkg::request_t    request,
	output logic                 busy,
	output logic                 result_valid,
	output pps_pkg::result_t     result
);

	logic          q_push;
	pps_pkg::cmd_t q_data;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	pps_pkg::cmd_t q_head;

	pps_front #(
		.MAX_TASKS (MAX_TASKS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.q_push  (q_push),
		.q_data  (q_data),
		.q_full  (q_full)
	);

	pps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	pps_back #(
		.MAX_TASKS  (MAX_TASKS),
		.TIME_WIDTH (TIME_WIDTH),
		.PRIO_WIDTH (PRIO_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire
